FILE: rtl/pfr_pkg.sv
`default_nettype none

package pfr_pkg;

    // Event codes carried on op
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Frame characters
    localparam logic [7:0] CH_OPEN  = 8'h3B;   // ';'
    localparam logic [7:0] CH_CLOSE = 8'h3A;   // ':'
    localparam logic [7:0] CH_SEP   = 8'h78;   // 'x'
    localparam logic [7:0] CH_ZERO  = 8'h30;   // '0'
    localparam logic [7:0] CH_SPACE = 8'h20;   // ' '

    localparam int          FRAME_DEPTH = 9;
    localparam logic [3:0]  FRAME_LEN   = 4'd9;
    localparam int          NUM_DIGITS  = 6;

    localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

    typedef logic [7:0] char_t;
    typedef char_t frame_buf_t [FRAME_DEPTH];
    typedef char_t digits_t [NUM_DIGITS];

endpackage : pfr_pkg

`default_nettype wire

FILE: rtl/pressure_frame_receiver_top.sv
// An event goes into the input register, then into the result register when the slot is free,
// and is offered on out_valid. Throughput: one event per cycle unless out_stall holds; while a
// result waits, one more event still enters the input register, then in_stall holds the input
// until the result moves. Reset (rst_n low, asynchronous): timeout register 5000, no frame open,
// buffer all spaces, timeout count 0, error flag set, latched digits all '0', both channels empty.
`default_nettype none

module pressure_frame_receiver_top
    import pfr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // event input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [7:0]  rx_byte,

    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             error_flag,
    output logic             frame_accepted,
    output logic [7:0]       digit_a0,
    output logic [7:0]       digit_a1,
    output logic [7:0]       digit_a2,
    output logic [7:0]       digit_b0,
    output logic [7:0]       digit_b1,
    output logic [7:0]       digit_b2,

    // configuration write channel (timeout in ticks)
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data
);

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic        in_valid_reg, in_valid_next;
    logic        op_reg;
    logic [7:0]  byte_reg;

    // Result register (digits and error flag are read straight from state,
    // which only moves when a new result is loaded)
    logic        out_valid_reg, out_valid_next;
    logic        accepted_reg, accepted_next;

    // Link state
    logic [15:0] timeout_ticks_reg;
    logic        frame_open_reg, frame_open_next;
    logic [3:0]  byte_count_reg, byte_count_next;
    frame_buf_t  frame_buf_reg, frame_buf_next;
    logic [15:0] timeout_count_reg, timeout_count_next;
    logic        error_reg, error_next;
    digits_t     digits_reg, digits_next;

    logic        in_xfer;
    logic        advance;

    // Byte path intermediates
    logic        open_now;
    logic        byte_taken;
    frame_buf_t  buf_store;
    logic [3:0]  count_store;
    logic        frame_done;
    logic        frame_ok;
    logic [15:0] timeout_inc;

    // An event moves into processing whenever the result slot is free or
    // is being emptied in this same cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_xfer  = in_valid && !in_stall;

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // Byte store: slot at byte_count gets the byte, if room remains
    // ------------------------------------------------------------------
    assign open_now    = frame_open_reg || (byte_reg == CH_OPEN);
    assign byte_taken  = open_now && (timeout_count_reg <= timeout_ticks_reg);
    assign timeout_inc = timeout_count_reg + 16'd1;

    always_comb
    begin
        buf_store   = frame_buf_reg;
        count_store = byte_count_reg;
        if (byte_count_reg < FRAME_LEN)
        begin
            buf_store[byte_count_reg] = byte_reg;
            count_store               = byte_count_reg + 4'd1;
        end
    end

    // Frame closes on the ninth byte or on a ':'; the form check looks at
    // the opener, separator and closer slots after this byte is stored.
    assign frame_done = (count_store >= FRAME_LEN) || (byte_reg == CH_CLOSE);
    assign frame_ok   = (buf_store[8] == CH_CLOSE) && (buf_store[4] == CH_SEP)
                     && (buf_store[0] == CH_OPEN);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        in_valid_next      = in_valid_reg;
        out_valid_next     = out_valid_reg;
        accepted_next      = accepted_reg;
        frame_open_next    = frame_open_reg;
        byte_count_next    = byte_count_reg;
        frame_buf_next     = frame_buf_reg;
        timeout_count_next = timeout_count_reg;
        error_next         = error_reg;
        digits_next        = digits_reg;

        if (in_xfer)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        if (advance)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        if (advance)
        begin
            accepted_next = 1'b0;
            if (op_reg == OP_TICK)
            begin
                // ticks only count while a frame is open
                if (frame_open_reg)
                begin
                    if (timeout_inc >= timeout_ticks_reg)
                    begin
                        timeout_count_next = '0;
                        error_next         = 1'b1;
                        frame_open_next    = 1'b0;
                        byte_count_next    = '0;
                        for (int i = 0; i < FRAME_DEPTH; i++)
                            frame_buf_next[i] = CH_ZERO;
                    end
                    else
                    begin
                        timeout_count_next = timeout_inc;
                    end
                end
            end
            else
            begin
                // a ';' marks the frame open even if the byte is refused
                frame_open_next = open_now;
                error_next      = 1'b1;
                if (byte_taken)
                begin
                    if (frame_done)
                    begin
                        if (frame_ok)
                        begin
                            error_next     = 1'b0;
                            accepted_next  = 1'b1;
                            digits_next[0] = buf_store[1];
                            digits_next[1] = buf_store[2];
                            digits_next[2] = buf_store[3];
                            digits_next[3] = buf_store[5];
                            digits_next[4] = buf_store[6];
                            digits_next[5] = buf_store[7];
                        end
                        frame_open_next = 1'b0;
                        byte_count_next = '0;
                        for (int i = 0; i < FRAME_DEPTH; i++)
                            frame_buf_next[i] = CH_ZERO;
                    end
                    else
                    begin
                        // mid-frame: stored, link still flagged busy
                        frame_buf_next  = buf_store;
                        byte_count_next = count_store;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            accepted_reg      <= 1'b0;
            timeout_ticks_reg <= TIMEOUT_RESET;
            frame_open_reg    <= 1'b0;
            byte_count_reg    <= '0;
            timeout_count_reg <= '0;
            error_reg         <= 1'b1;
            for (int i = 0; i < FRAME_DEPTH; i++)
                frame_buf_reg[i] <= CH_SPACE;
            for (int i = 0; i < NUM_DIGITS; i++)
                digits_reg[i] <= CH_ZERO;
        end
        else
        begin
            in_valid_reg      <= in_valid_next;
            out_valid_reg     <= out_valid_next;
            accepted_reg      <= accepted_next;
            frame_open_reg    <= frame_open_next;
            byte_count_reg    <= byte_count_next;
            timeout_count_reg <= timeout_count_next;
            error_reg         <= error_next;
            frame_buf_reg     <= frame_buf_next;
            digits_reg        <= digits_next;
            if (cfg_valid && cfg_ready)
                timeout_ticks_reg <= cfg_data;
        end
    end

    // Payload of the input stage: loaded on each transfer, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg   <= op;
            byte_reg <= rx_byte;
        end
    end

    // ------------------------------------------------------------------
    // Outputs
    // ------------------------------------------------------------------
    assign out_valid      = out_valid_reg;
    assign frame_accepted = accepted_reg;
    assign error_flag     = error_reg;
    assign digit_a0       = digits_reg[0];
    assign digit_a1       = digits_reg[1];
    assign digit_a2       = digits_reg[2];
    assign digit_b0       = digits_reg[3];
    assign digit_b1       = digits_reg[4];
    assign digit_b2       = digits_reg[5];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef ASSERT_OFF
    // a good frame always leaves the link out of error
    a_accept_clears_error: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_accepted) |-> !error_flag)
        else $error("frame accepted with error flag set");

    // buffer never fills past its last slot without closing
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg < FRAME_LEN)
        else $error("byte count out of range");

    // a closed frame holds no bytes
    a_closed_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_open_reg |-> (byte_count_reg == 4'd0))
        else $error("bytes held with no frame open");

    // state only moves when a result is produced
    a_state_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(error_reg) && $stable(frame_open_reg)))
        else $error("link state changed without an event");
`endif

endmodule : pressure_frame_receiver_top

`default_nettype wire

FILE: test/pressure_frame_receiver_top_tb.sv
`timescale 1ns / 1ps

module pressure_frame_receiver_top_tb;
    import pfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;   // cycles with no transfer on any channel
    localparam int DRAIN_CYCLES   = 8;      // margin left after the last expected result
    localparam int SCRIPT_LEN     = 19;

    localparam logic [0:5][7:0] DIG_RESET  = "000000";
    localparam logic [0:5][7:0] DIG_SAMPLE = "123456";

    // One result as seen on the output channel; digits[0] is a0, digits[5] is b2
    typedef struct packed {
        logic            error_flag;
        logic            frame_accepted;
        logic [0:5][7:0] digits;
    } reading_t;

    typedef struct packed {
        logic     ev_op;
        char_t    ch;
        logic     typed;    // 1: use the reading below rather than the predictor
        reading_t want;
    } script_row_t;

    // Directed opening: link errors with no frame open, one clean frame, then a
    // frame with a second ';' inside it closed early by ':'
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{OP_TICK, 8'h00, 1'b1, '{1'b1, 1'b0, DIG_RESET}},    // tick, nothing open
        '{OP_BYTE, "A",   1'b1, '{1'b1, 1'b0, DIG_RESET}},    // stray byte
        '{OP_BYTE, 8'h00, 1'b1, '{1'b1, 1'b0, DIG_RESET}},
        '{OP_BYTE, 8'hFF, 1'b1, '{1'b1, 1'b0, DIG_RESET}},
        '{OP_BYTE, ";",   1'b1, '{1'b1, 1'b0, DIG_RESET}},    // frame opens
        '{OP_BYTE, "1",   1'b1, '{1'b1, 1'b0, DIG_RESET}},
        '{OP_BYTE, "2",   1'b1, '{1'b1, 1'b0, DIG_RESET}},
        '{OP_BYTE, "3",   1'b1, '{1'b1, 1'b0, DIG_RESET}},
        '{OP_BYTE, "x",   1'b1, '{1'b1, 1'b0, DIG_RESET}},
        '{OP_BYTE, "4",   1'b1, '{1'b1, 1'b0, DIG_RESET}},
        '{OP_BYTE, "5",   1'b1, '{1'b1, 1'b0, DIG_RESET}},
        '{OP_BYTE, "6",   1'b1, '{1'b1, 1'b0, DIG_RESET}},
        '{OP_BYTE, ":",   1'b1, '{1'b0, 1'b1, DIG_SAMPLE}},   // good frame latched
        '{OP_TICK, 8'hFF, 1'b1, '{1'b0, 1'b0, DIG_SAMPLE}},   // idle tick, no change
        '{OP_BYTE, ";",   1'b1, '{1'b1, 1'b0, DIG_SAMPLE}},
        '{OP_BYTE, ";",   1'b1, '{1'b1, 1'b0, DIG_SAMPLE}},   // stored, no restart
        '{OP_TICK, 8'h5A, 1'b0, '0},                         // timeout count moves
        '{OP_BYTE, ":",   1'b1, '{1'b1, 1'b0, DIG_SAMPLE}},   // early close, bad form
        '{OP_BYTE, 8'h80, 1'b0, '0}                          // refused, nothing open
    };

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        op        = OP_BYTE;
    logic [7:0]  rx_byte   = 8'h00;
    logic        out_stall = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [15:0] cfg_data  = 16'h0000;

    logic        in_stall;
    logic        out_valid;
    logic        error_flag;
    logic        frame_accepted;
    logic [7:0]  digit_a0, digit_a1, digit_a2;
    logic [7:0]  digit_b0, digit_b1, digit_b2;
    logic        cfg_ready;

    // Side-band for the directed table, travels with the payload
    logic        ev_typed = 1'b0;
    reading_t    ev_want  = '0;

    // Receiver-side model of the link
    logic [15:0] timeout_reg;
    logic        frm_open;
    logic [3:0]  frm_count;
    char_t       frm_buf [FRAME_DEPTH];
    logic [15:0] tick_count;
    logic        link_err;
    logic [0:5][7:0] latched;

    reading_t    reading_q [$];

    int n_errors    = 0;
    int n_live      = 0;   // events that can change the link state
    int n_results   = 0;
    int n_frames_ok = 0;
    int n_timeouts  = 0;
    int n_settings  = 0;
    int idle_cycles = 0;
    int src_idle    = 0;   // percent chance of a gap before each event
    int dst_idle    = 0;   // percent chance of a stall on the result channel

    always #5 clk = ~clk;

    pressure_frame_receiver_top u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .error_flag     (error_flag),
        .frame_accepted (frame_accepted),
        .digit_a0       (digit_a0),
        .digit_a1       (digit_a1),
        .digit_a2       (digit_a2),
        .digit_b0       (digit_b0),
        .digit_b1       (digit_b1),
        .digit_b2       (digit_b2),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    function automatic void drop_frame();
        frm_open  = 1'b0;
        frm_count = '0;
        foreach (frm_buf[i])
            frm_buf[i] = CH_ZERO;
    endfunction

    // Advances the link model by one event and returns the reading it should produce
    function automatic reading_t decode_event(logic ev_op, char_t ch);
        reading_t r;
        logic     closing;
        r = '0;
        if (ev_op == OP_TICK) begin
            // ticks only matter while a frame is open
            if (frm_open) begin
                tick_count = tick_count + 16'd1;
                if (tick_count >= timeout_reg) begin
                    tick_count = '0;
                    link_err   = 1'b1;
                    drop_frame();
                    n_timeouts++;
                end
            end
        end else begin
            // a ';' marks the frame open even when the byte itself is refused
            if (ch == CH_OPEN)
                frm_open = 1'b1;
            if (frm_open && tick_count <= timeout_reg) begin
                if (frm_count < FRAME_LEN) begin
                    frm_buf[frm_count] = ch;
                    frm_count = frm_count + 4'd1;
                end
                closing = (frm_count >= FRAME_LEN) || (ch == CH_CLOSE);
                if (closing) begin
                    if (frm_buf[8] == CH_CLOSE && frm_buf[4] == CH_SEP &&
                        frm_buf[0] == CH_OPEN) begin
                        link_err         = 1'b0;
                        r.frame_accepted = 1'b1;
                        latched = {frm_buf[1], frm_buf[2], frm_buf[3],
                                   frm_buf[5], frm_buf[6], frm_buf[7]};
                        n_frames_ok++;
                    end else begin
                        link_err = 1'b1;
                    end
                    drop_frame();
                end else begin
                    link_err = 1'b1;    // still mid-frame
                end
            end else begin
                link_err = 1'b1;        // nothing open, or the count has overrun
            end
        end
        r.error_flag = link_err;
        r.digits     = latched;
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned seen);
        if (want != seen) begin
            n_errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, seen);
        end
    endtask

    // Result channel back-pressure, redrawn every cycle
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < dst_idle);

    // Everything is sampled at the rising edge, before the block's own updates land
    always @(posedge clk) begin : scoreboard
        reading_t predicted;
        reading_t seen;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                timeout_reg = cfg_data;
                n_settings++;
            end
            if (in_valid && !in_stall) begin
                if (op == OP_BYTE || frm_open)
                    n_live++;
                predicted = decode_event(op, rx_byte);
                reading_q.push_back(ev_typed ? ev_want : predicted);
            end
            if (out_valid && !out_stall) begin
                n_results++;
                seen.error_flag     = error_flag;
                seen.frame_accepted = frame_accepted;
                seen.digits = {digit_a0, digit_a1, digit_a2, digit_b0, digit_b1, digit_b2};
                if (reading_q.size() == 0) begin
                    n_errors++;
                    $display("%0t: result with nothing expected, expected none, got 0x%0h",
                             $time, seen);
                end else begin
                    predicted = reading_q.pop_front();
                    check_field("error_flag", predicted.error_flag, seen.error_flag);
                    check_field("frame_accepted", predicted.frame_accepted,
                                seen.frame_accepted);
                    for (int k = 0; k < NUM_DIGITS; k++)
                        check_field($sformatf("digit_%s%0d", (k < 3) ? "a" : "b", k % 3),
                                    predicted.digits[k], seen.digits[k]);
                end
            end
            // watchdog: any transfer on any channel counts as progress
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("pressure_frame_receiver_top_tb: done, errors");
                $finish;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    // in_valid is left high so back-to-back events need no second assignment.
    task automatic send_event(logic ev_op, char_t ch, logic typed = 1'b0,
                              reading_t want = '0);
        while ($urandom_range(99) < src_idle) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op       <= ev_op;
        rx_byte  <= ch;
        ev_typed <= typed;
        ev_want  <= want;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
    endtask

    // Register writes only once the link has gone quiet
    task automatic write_timeout(logic [15:0] ticks);
        in_valid <= 1'b0;
        while (reading_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= ticks;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed frames with random digits, plus broken frames,
    // frames left to run out of time, and raw noise
    task automatic run_traffic(int target);
        int    stop_at;
        int    kind;
        int    len;
        char_t ch;
        stop_at = n_live + target;
        while (n_live < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                for (int k = 0; k < FRAME_DEPTH; k++) begin
                    if ($urandom_range(99) < 10)
                        send_event(OP_TICK, char_t'($urandom));
                    case (k)
                        0:       ch = CH_OPEN;
                        4:       ch = CH_SEP;
                        8:       ch = CH_CLOSE;
                        default: ch = ($urandom_range(15) == 0) ? char_t'($urandom)
                                                               : CH_ZERO + char_t'($urandom_range(9));
                    endcase
                    send_event(OP_BYTE, ch);
                end
            end else if (kind < 72) begin
                len = $urandom_range(11, 1);
                for (int k = 0; k < len; k++) begin
                    case ($urandom_range(9))
                        0, 1, 2: ch = CH_ZERO + char_t'($urandom_range(9));
                        3:       ch = CH_CLOSE;
                        4:       ch = CH_OPEN;
                        5:       ch = CH_SEP;
                        default: ch = char_t'($urandom);
                    endcase
                    if (k == 0 && $urandom_range(4) != 0)
                        ch = CH_OPEN;
                    send_event(OP_BYTE, ch);
                end
            end else if (kind < 85) begin
                send_event(OP_BYTE, CH_OPEN);
                len = $urandom_range(2 + ((timeout_reg < 20) ? int'(timeout_reg) : 20), 1);
                repeat (len) send_event(OP_TICK, char_t'($urandom));
            end else begin
                repeat ($urandom_range(4, 1))
                    send_event(logic'($urandom_range(1)), char_t'($urandom));
            end
        end
    endtask

    initial begin
        // model state after reset
        timeout_reg = TIMEOUT_RESET;
        frm_open    = 1'b0;
        frm_count   = '0;
        foreach (frm_buf[i])
            frm_buf[i] = CH_SPACE;
        tick_count  = '0;
        link_err    = 1'b1;
        latched     = DIG_RESET;

        src_idle = 17;
        dst_idle = 49;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int k = 0; k < SCRIPT_LEN; k++)
            send_event(SCRIPT[k].ev_op, SCRIPT[k].ch, SCRIPT[k].typed, SCRIPT[k].want);

        // shortest timeout: every open frame dies on its first tick
        write_timeout(16'd1);
        run_traffic(170);
        // longest timeout: the count only grows across frames
        write_timeout(16'hFFFF);
        run_traffic(170);

        src_idle = 49;
        dst_idle = 17;
        // dropping the limit below a grown count makes bytes get refused
        write_timeout(16'd3);
        run_traffic(170);
        write_timeout(16'd9);
        run_traffic(170);

        src_idle = 0;
        dst_idle = 0;
        write_timeout(16'($urandom_range(40, 2)));
        run_traffic(170);

        in_valid <= 1'b0;
        while (reading_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Link exercised with %0d live events: %0d frames latched, %0d timeouts.",
                 n_live, n_frames_ok, n_timeouts);
        $display("%0d readings checked across %0d timeout settings.", n_results, n_settings);
        if (n_errors == 0)
            $display("pressure_frame_receiver_top_tb: done, clean");
        else
            $display("pressure_frame_receiver_top_tb: done, errors");
        $finish;
    end

endmodule

FILE: files.f
rtl/pfr_pkg.sv
rtl/pressure_frame_receiver_top.sv
test/pressure_frame_receiver_top_tb.sv
